// ===== rtl/finito_logistic_update_unit_assert.svh =====
// assertion macros shared by the finito logistic update unit rtl
// no dependencies; included inside module bodies
`ifndef FINITO_LOGISTIC_UPDATE_UNIT_ASSERT_SVH
`define FINITO_LOGISTIC_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FLU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication, disabled during reset
`define FLU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// ===== rtl/flu_pkg.sv =====
// shared types, constants and helper functions of the finito logistic update unit
// no dependencies
package flu_pkg;

  // sizing
  localparam int unsigned MAX_SAMPLES  = 1024;
  localparam int unsigned MAX_FEATURES = 64;
  localparam int unsigned SIG_DEPTH    = 256;

  // field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned ROW_W  = 10;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned GAIN_W = 31;
  localparam int unsigned SCNT_W = 11;
  localparam int unsigned FCNT_W = 7;
  localparam int unsigned APB_AW = 4;

  // derived widths
  localparam int unsigned FEAT_DEPTH = MAX_SAMPLES * MAX_FEATURES;
  localparam int unsigned FEAT_AW    = $clog2(FEAT_DEPTH);
  localparam int unsigned AVG_AW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned LBL_AW     = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W      = $clog2(MAX_FEATURES + 1);
  localparam int unsigned NCNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SIG_W      = 17;
  localparam int unsigned SIG_IW     = $clog2(SIG_DEPTH);
  localparam int unsigned OPD_W      = 33;
  localparam int unsigned PROD_W     = 2 * OPD_W;
  localparam int unsigned SH_W       = PROD_W - 16;
  localparam int unsigned T1_W       = SH_W + 1;
  localparam int unsigned SCL_W      = 33 + SIG_IW + 1;

  // fixed point constants
  localparam longint ONE_Q16        = 65536;
  localparam longint RANGE_HALF_Q16 = 524288;
  localparam longint unsigned EXP_MINUS_ONE_Q32 = 64'd1580030169;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_FEAT  = 2'd0,
    MODE_LOAD_LABEL = 2'd1,
    MODE_UPDATE     = 2'd2,
    MODE_READ_AVG   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_STEP_SIZE     = 2'd0,
    REG_REG_WEIGHT    = 2'd1,
    REG_SAMPLE_COUNT  = 2'd2,
    REG_FEATURE_COUNT = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_AVG_X,
    MUL_Y_DOT,
    MUL_G_Y,
    MUL_GY_X,
    MUL_REG_AVG,
    MUL_STEP_GRAD
  } mul_sel_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DOT_RD,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_DOT_SAT,
    ST_MARGIN,
    ST_INDEX,
    ST_GY_MUL,
    ST_GY,
    ST_U_RD,
    ST_U_M1,
    ST_U_M2,
    ST_U_GRAD,
    ST_U_M3,
    ST_U_DELTA,
    ST_U_DSTART,
    ST_U_DIV,
    ST_U_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [GAIN_W-1:0] step_size;
    logic [GAIN_W-1:0] reg_weight;
    logic [SCNT_W-1:0] sample_count;
    logic [FCNT_W-1:0] feature_count;
  } cfg_t;

  typedef struct packed {
    logic     accept;
    logic     clr_step;
    logic     feat_we;
    logic     label_we;
    logic     rd_item;
    logic     rd_coord;
    logic     rd_label;
    logic     acc_clr;
    logic     acc_en;
    logic     cnt_clr;
    logic     cnt_inc;
    mul_sel_e mul_sel;
    logic     prod_en;
    logic     dot_en;
    logic     idx_en;
    logic     gy_en;
    logic     t1_en;
    logic     grad_en;
    logic     delta_en;
    logic     div_start;
    logic     upd_we;
    logic     res_load;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  item_ok;
    logic  nf_zero;
    logic  coord_last;
    logic  clr_last;
    logic  div_done;
    logic  out_free;
  } stat_t;

  typedef logic [SIG_DEPTH-1:0][SIG_W-1:0] sig_table_t;

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // unsigned shift-subtract quotient, only used while building the table
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= den) begin
        rem  = rem - den;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^(-a) in q0.32 for q16.16 a below 16, taylor series
  function automatic longint unsigned exp_neg_q32(longint a);
    longint whole;
    longint unsigned frac;
    longint unsigned term;
    longint sum;
    longint unsigned r;
    whole = a >>> 16;
    frac  = longint'(a & 64'hFFFF);
    term  = 64'd1 << 32;
    sum   = longint'(term);
    for (int i = 1; i <= 12; i++) begin
      term = udiv64((term * frac) >> 16, longint'(i));
      if ((i % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    r = longint'(sum);
    for (int j = 0; j < 16; j++) begin
      if (longint'(j) < whole) begin
        r = (r * EXP_MINUS_ONE_Q32) >> 32;
      end
    end
    return r;
  endfunction

  // rounded 1/(1+e) in q16.16 with e in q0.32
  function automatic longint unsigned recip_one_plus(longint unsigned r);
    longint unsigned den;
    den = (64'd1 << 32) + r;
    return udiv64((64'd1 << 48) + (den >> 1), den);
  endfunction

  // logistic table over cell midpoints of [-8, 8]
  function automatic sig_table_t build_sig_table();
    sig_table_t tbl;
    longint u;
    for (int k = 0; k < SIG_DEPTH; k++) begin
      u = ((2 * longint'(k) + 1) * RANGE_HALF_Q16) / SIG_DEPTH - RANGE_HALF_Q16;
      if (u <= 0) begin
        tbl[k] = SIG_W'(recip_one_plus(exp_neg_q32(-u)));
      end else begin
        tbl[k] = SIG_W'(ONE_Q16 - longint'(recip_one_plus(exp_neg_q32(u))));
      end
    end
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// ===== rtl/finito_logistic_update_unit.sv =====
// top level of the finito logistic update unit: apb register file, controller, datapath
// depends on flu_pkg, flu_ctrl, flu_datapath and the assertion macro header
//
// usage:
//   input beats (mode, sample_index, coord_index, data_value) enter on a valid/ready
//   channel; every beat produces exactly one output beat (result_value, status) on a
//   valid/ready channel. mode 0 loads a feature, 1 a label, 2 runs one update of a
//   sample, 3 reads an average coordinate. status 1 flags an index beyond the
//   configured counts; the beat is then dropped with result zero.
//   the block works on one item at a time. an update makes a dot pass over the nf
//   features in use on the shared multiplier, then an update pass that works each
//   coordinate on the multiplier and the bit-serial divider for delta over
//   sample_count. after reset a clearing sweep zeroes the per-sample vectors and the
//   average, one entry a cycle, over all MAX_SAMPLES*MAX_FEATURES entries (65536);
//   no input beat is taken meanwhile, apb writes are. results sit in an output
//   register; while the receiver stalls, one more item is taken and worked, its beat
//   waits in the last step until the register frees, and no further input beat is
//   taken meanwhile. registers are to be written over apb only while the block is
//   idle; the block itself does not enforce this.
module finito_logistic_update_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // apb configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [flu_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [flu_pkg::MODE_W-1:0] mode_i,
  input  logic [flu_pkg::ROW_W-1:0]  sample_index_i,
  input  logic [flu_pkg::COL_W-1:0]  coord_index_i,
  input  logic signed [31:0]         data_value_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         result_value_o,
  output logic                       status_o
);
  import flu_pkg::*;
  `include "finito_logistic_update_unit_assert.svh"

  cfg_t     cfg_q;
  cmd_t     cmd;
  stat_t    stat;
  reg_idx_e reg_idx;
  logic     cfg_we;

  // apb register file
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size     <= GAIN_W'(655);
      cfg_q.reg_weight    <= '0;
      cfg_q.sample_count  <= SCNT_W'(1024);
      cfg_q.feature_count <= FCNT_W'(64);
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_STEP_SIZE:     cfg_q.step_size     <= pwdata[GAIN_W-1:0];
        REG_REG_WEIGHT:    cfg_q.reg_weight    <= pwdata[GAIN_W-1:0];
        REG_SAMPLE_COUNT:  cfg_q.sample_count  <= pwdata[SCNT_W-1:0];
        REG_FEATURE_COUNT: cfg_q.feature_count <= pwdata[FCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_STEP_SIZE:     prdata = 32'(cfg_q.step_size);
      REG_REG_WEIGHT:    prdata = 32'(cfg_q.reg_weight);
      REG_SAMPLE_COUNT:  prdata = 32'(cfg_q.sample_count);
      REG_FEATURE_COUNT: prdata = 32'(cfg_q.feature_count);
      default:           prdata = '0;
    endcase
  end

  flu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  flu_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_i          (cfg_q),
    .mode_i         (mode_i),
    .sample_index_i (sample_index_i),
    .coord_index_i  (coord_index_i),
    .data_value_i   (data_value_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

  // one item in flight: no input beat right after an accepted one
  `FLU_ASSERT_NXT(a_single_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

// ===== rtl/flu_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module flu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/flu_div.sv =====
// restoring divider: signed 32-bit dividend by unsigned sample count, one bit a cycle
// depends on flu_pkg
module flu_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [31:0]         dividend_i,
  input  logic [flu_pkg::NCNT_W-1:0] divisor_i,
  output logic                       done_o,
  output logic signed [31:0]         quotient_o
);
  import flu_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              neg_q;
  logic [31:0]       work_q;
  logic [NCNT_W-1:0] rem_q;
  logic [NCNT_W:0]   rem_sh;
  logic              ge;

  // one restoring step
  assign rem_sh = {rem_q, work_q[31]};
  assign ge     = rem_sh >= {1'b0, divisor_i};

  // control
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = 6'd32;
    end else if (busy_q) begin
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers: dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= dividend_i[31];
      work_q <= dividend_i[31] ? 32'(-dividend_i) : 32'(dividend_i);
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? NCNT_W'(rem_sh - {1'b0, divisor_i}) : NCNT_W'(rem_sh);
      work_q <= {work_q[30:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(work_q) : $signed(work_q);

endmodule

// ===== rtl/flu_datapath.sv =====
// datapath: sample stores, average and per-sample vectors, shared multiplier,
// logistic table, divider and result register; depends on flu_pkg, flu_ram, flu_div
module flu_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  flu_pkg::cmd_t              cmd_i,
  output flu_pkg::stat_t             stat_o,
  input  flu_pkg::cfg_t              cfg_i,
  input  logic [flu_pkg::MODE_W-1:0] mode_i,
  input  logic [flu_pkg::ROW_W-1:0]  sample_index_i,
  input  logic [flu_pkg::COL_W-1:0]  coord_index_i,
  input  logic signed [31:0]         data_value_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [31:0]         result_value_o,
  output logic                       status_o
);
  import flu_pkg::*;

  // captured item
  mode_e              mode_q;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic signed [31:0] data_q;

  // counters
  logic [FEAT_AW-1:0] clr_q;
  logic [CNT_W-1:0]   c_q;

  // limits and checks
  logic [CNT_W-1:0]   nf;
  logic [NCNT_W-1:0]  n_use;
  logic               row_ok, col_ok, item_ok;

  // addresses
  logic [FEAT_AW-1:0] feat_base, feat_ld_addr, feat_c_addr;

  // memory read data
  logic signed [31:0] x_rd, y_rd, z_rd, avg_rd;

  // arithmetic
  logic signed [OPD_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SH_W-1:0]   prod_sh;
  logic signed [63:0]       acc_q;
  logic signed [31:0]       dot_q, margin, grad_q, delta_q, div_q;
  logic signed [33:0]       shifted;
  logic [32:0]              pos;
  logic [SCL_W-1:0]         scaled;
  logic [SCL_W-21:0]        k_raw;
  logic [SIG_IW-1:0]        idx_q, idx_d;
  logic [SIG_W-1:0]         g;
  logic signed [OPD_W-1:0]  gy_q;
  logic signed [T1_W-1:0]   t1_q;
  logic signed [31:0]       z_new, avg_new;
  logic                     div_done;

  // result register
  logic                     out_valid_q;
  logic signed [31:0]       result_q;
  logic                     status_q;
  logic signed [31:0]       result_d;

  // capture item on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_e'(mode_i);
      row_q  <= sample_index_i;
      col_q  <= coord_index_i;
      data_q <= data_value_i;
    end
  end

  // counts in use, saturated to store sizes
  assign nf    = (32'(cfg_i.feature_count) > MAX_FEATURES) ? CNT_W'(MAX_FEATURES)
                                                           : CNT_W'(cfg_i.feature_count);
  assign n_use = (32'(cfg_i.sample_count) > MAX_SAMPLES) ? NCNT_W'(MAX_SAMPLES)
                                                         : NCNT_W'(cfg_i.sample_count);
  assign row_ok = 32'(row_q) < 32'(n_use);
  assign col_ok = 32'(col_q) < 32'(nf);

  // index check per mode
  always_comb begin
    case (mode_q)
      MODE_LOAD_FEAT:  item_ok = row_ok && col_ok;
      MODE_LOAD_LABEL: item_ok = row_ok;
      MODE_UPDATE:     item_ok = row_ok;
      MODE_READ_AVG:   item_ok = col_ok;
      default:         item_ok = 1'b0;
    endcase
  end

  // clearing sweep and coordinate counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      c_q   <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + FEAT_AW'(1);
      end
      if (cmd_i.cnt_clr) begin
        c_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        c_q <= c_q + CNT_W'(1);
      end
    end
  end

  // row-major feature and per-sample addresses
  assign feat_base    = FEAT_AW'(row_q) * FEAT_AW'(MAX_FEATURES);
  assign feat_ld_addr = feat_base + FEAT_AW'(col_q);
  assign feat_c_addr  = feat_base + FEAT_AW'(c_q);

  // stores
  flu_ram #(.WIDTH(32), .DEPTH(FEAT_DEPTH)) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.feat_we),
    .waddr_i (feat_ld_addr),
    .wdata_i (data_q),
    .re_i    (cmd_i.rd_coord),
    .raddr_i (feat_c_addr),
    .rdata_o (x_rd)
  );

  flu_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.label_we),
    .waddr_i (LBL_AW'(row_q)),
    .wdata_i (data_q),
    .re_i    (cmd_i.rd_label),
    .raddr_i (LBL_AW'(row_q)),
    .rdata_o (y_rd)
  );

  flu_ram #(.WIDTH(32), .DEPTH(FEAT_DEPTH)) u_z_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_step || cmd_i.upd_we),
    .waddr_i (cmd_i.clr_step ? clr_q : feat_c_addr),
    .wdata_i (cmd_i.clr_step ? 32'sd0 : z_new),
    .re_i    (cmd_i.rd_coord),
    .raddr_i (feat_c_addr),
    .rdata_o (z_rd)
  );

  flu_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES)) u_avg_ram (
    .clk_i   (clk_i),
    .we_i    ((cmd_i.clr_step && (32'(clr_q) < MAX_FEATURES)) || cmd_i.upd_we),
    .waddr_i (cmd_i.clr_step ? AVG_AW'(clr_q) : AVG_AW'(c_q)),
    .wdata_i (cmd_i.clr_step ? 32'sd0 : avg_new),
    .re_i    (cmd_i.rd_coord || cmd_i.rd_item),
    .raddr_i (cmd_i.rd_item ? AVG_AW'(col_q) : AVG_AW'(c_q)),
    .rdata_o (avg_rd)
  );

  // shared multiplier operand select
  assign g = SIG_TABLE[idx_q];
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_AVG_X: begin
        mul_a = OPD_W'(avg_rd);
        mul_b = OPD_W'(x_rd);
      end
      MUL_Y_DOT: begin
        mul_a = OPD_W'(y_rd);
        mul_b = OPD_W'(dot_q);
      end
      MUL_G_Y: begin
        mul_a = $signed({{(OPD_W-SIG_W){1'b0}}, g});
        mul_b = OPD_W'(y_rd);
      end
      MUL_GY_X: begin
        mul_a = gy_q;
        mul_b = OPD_W'(x_rd);
      end
      MUL_REG_AVG: begin
        mul_a = $signed({{(OPD_W-GAIN_W){1'b0}}, cfg_i.reg_weight});
        mul_b = OPD_W'(avg_rd);
      end
      MUL_STEP_GRAD: begin
        mul_a = $signed({{(OPD_W-GAIN_W){1'b0}}, cfg_i.step_size});
        mul_b = OPD_W'(grad_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product register, floor shift by 16 is the upper slice
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      prod_q <= mul_a * mul_b;
    end
  end
  assign prod_sh = prod_q[PROD_W-1:16];

  // logistic table index from the margin
  assign margin  = sat32(64'(prod_sh));
  assign shifted = 34'(margin) + 34'(RANGE_HALF_Q16);
  assign pos     = shifted[33] ? '0 : shifted[32:0];
  assign scaled  = SCL_W'(pos) * SCL_W'(SIG_DEPTH);
  assign k_raw   = scaled[SCL_W-1:20];
  assign idx_d   = (32'(k_raw) >= SIG_DEPTH) ? SIG_IW'(SIG_DEPTH - 1) : SIG_IW'(k_raw);

  // per-coordinate results
  assign z_new   = sat32(64'(z_rd) + 64'(delta_q));
  assign avg_new = sat32(64'(avg_rd) + 64'(div_q));

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + 64'(prod_sh);
    end
    if (cmd_i.dot_en) begin
      dot_q <= sat32(acc_q);
    end
    if (cmd_i.idx_en) begin
      idx_q <= idx_d;
    end
    if (cmd_i.gy_en) begin
      gy_q <= prod_sh[OPD_W-1:0];
    end
    if (cmd_i.t1_en) begin
      t1_q <= -T1_W'(prod_sh);
    end
    if (cmd_i.grad_en) begin
      grad_q <= sat32(64'(t1_q) + 64'(prod_sh));
    end
    if (cmd_i.delta_en) begin
      delta_q <= sat32(64'(avg_rd) - 64'(z_rd) - 64'(prod_sh));
    end
  end

  // delta over sample count
  flu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (delta_q),
    .divisor_i  (n_use),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // result value per mode
  always_comb begin
    result_d = 32'sd0;
    if (item_ok) begin
      case (mode_q)
        MODE_READ_AVG: result_d = avg_rd;
        MODE_UPDATE:   result_d = dot_q;
        default:       result_d = 32'sd0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      result_q <= result_d;
      status_q <= !item_ok;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;

  // status to the controller
  assign stat_o.mode       = mode_q;
  assign stat_o.item_ok    = item_ok;
  assign stat_o.nf_zero    = (nf == '0);
  assign stat_o.coord_last = ((c_q + CNT_W'(1)) == nf);
  assign stat_o.clr_last   = (32'(clr_q) == FEAT_DEPTH - 1);
  assign stat_o.div_done   = div_done;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/flu_ctrl.sv =====
// controller: sequences clearing, loads, reads and the two update passes
// depends on flu_pkg and the assertion macro header
module flu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  flu_pkg::stat_t stat_i,
  output flu_pkg::cmd_t  cmd_o
);
  import flu_pkg::*;
  `include "finito_logistic_update_unit_assert.svh"

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_AVG_X;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!stat_i.item_ok) begin
          state_d = ST_RESP;
        end else begin
          unique case (stat_i.mode)
            MODE_LOAD_FEAT: begin
              cmd_o.feat_we = 1'b1;
              state_d       = ST_RESP;
            end
            MODE_LOAD_LABEL: begin
              cmd_o.label_we = 1'b1;
              state_d        = ST_RESP;
            end
            MODE_READ_AVG: begin
              cmd_o.rd_item = 1'b1;
              state_d       = ST_RESP;
            end
            MODE_UPDATE: begin
              cmd_o.rd_label = 1'b1;
              cmd_o.acc_clr  = 1'b1;
              cmd_o.cnt_clr  = 1'b1;
              state_d        = stat_i.nf_zero ? ST_DOT_SAT : ST_DOT_RD;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      // first pass: dot product of average and sample
      ST_DOT_RD: begin
        cmd_o.rd_coord = 1'b1;
        state_d        = ST_DOT_MUL;
      end
      ST_DOT_MUL: begin
        cmd_o.mul_sel = MUL_AVG_X;
        cmd_o.prod_en = 1'b1;
        state_d       = ST_DOT_ACC;
      end
      ST_DOT_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (stat_i.coord_last) begin
          state_d = ST_DOT_SAT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_DOT_RD;
        end
      end
      ST_DOT_SAT: begin
        cmd_o.dot_en = 1'b1;
        state_d      = stat_i.nf_zero ? ST_RESP : ST_MARGIN;
      end
      // logistic gain times label
      ST_MARGIN: begin
        cmd_o.mul_sel = MUL_Y_DOT;
        cmd_o.prod_en = 1'b1;
        state_d       = ST_INDEX;
      end
      ST_INDEX: begin
        cmd_o.idx_en = 1'b1;
        state_d      = ST_GY_MUL;
      end
      ST_GY_MUL: begin
        cmd_o.mul_sel = MUL_G_Y;
        cmd_o.prod_en = 1'b1;
        state_d       = ST_GY;
      end
      ST_GY: begin
        cmd_o.gy_en   = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        state_d       = ST_U_RD;
      end
      // second pass: per-coordinate delta and writeback
      ST_U_RD: begin
        cmd_o.rd_coord = 1'b1;
        state_d        = ST_U_M1;
      end
      ST_U_M1: begin
        cmd_o.mul_sel = MUL_GY_X;
        cmd_o.prod_en = 1'b1;
        state_d       = ST_U_M2;
      end
      ST_U_M2: begin
        cmd_o.t1_en   = 1'b1;
        cmd_o.mul_sel = MUL_REG_AVG;
        cmd_o.prod_en = 1'b1;
        state_d       = ST_U_GRAD;
      end
      ST_U_GRAD: begin
        cmd_o.grad_en = 1'b1;
        state_d       = ST_U_M3;
      end
      ST_U_M3: begin
        cmd_o.mul_sel = MUL_STEP_GRAD;
        cmd_o.prod_en = 1'b1;
        state_d       = ST_U_DELTA;
      end
      ST_U_DELTA: begin
        cmd_o.delta_en = 1'b1;
        state_d        = ST_U_DSTART;
      end
      ST_U_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_U_DIV;
      end
      ST_U_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_U_WR;
        end
      end
      ST_U_WR: begin
        cmd_o.upd_we = 1'b1;
        if (stat_i.coord_last) begin
          state_d = ST_RESP;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_U_RD;
        end
      end
      // hand the result beat to the output register
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // writeback only with a finished quotient
  `FLU_ASSERT_IMP(a_wr_after_div, clk_i, rst_ni, state_q == ST_U_WR, stat_i.div_done)
  // a pending result beat is never overwritten
  `FLU_ASSERT_IMP(a_res_slot_free, clk_i, rst_ni, cmd_o.res_load, stat_i.out_free)

endmodule

// ===== test/finito_logistic_update_unit_test.sv =====
// self-checking testbench of the finito logistic update unit: directed table, then random beats
// depends on flu_pkg and finito_logistic_update_unit; expectations: inline model or typed rows
module finito_logistic_update_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import flu_pkg::*;

  localparam int unsigned STALL_LIMIT = 6_000_000;
  localparam longint unsigned EXP_M1_Q32 = 64'd1580030169;
  localparam longint HALF_RANGE = 524288;

  typedef struct {
    mode_e       mode;
    logic [9:0]  row;
    logic [5:0]  col;
    logic [31:0] data;
    bit          typed;
    logic [31:0] res;
    logic        stat;
  } beat_t;

  typedef struct {
    logic [31:0] res;
    logic        stat;
  } outcome_t;

  typedef struct {
    int unsigned step, wreg, nsamp, nfeat, count;
    bit          squeeze;
  } phase_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i, status_o;
  logic [MODE_W-1:0] mode_i;
  logic [ROW_W-1:0]  sample_index_i;
  logic [COL_W-1:0]  coord_index_i;
  logic signed [31:0] data_value_i, result_value_o;

  finito_logistic_update_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow state of the trainer
  int          feat_mem [MAX_SAMPLES][MAX_FEATURES];
  int          label_mem [MAX_SAMPLES];
  int          z_mem [MAX_SAMPLES][MAX_FEATURES];
  int          avg_vec [MAX_FEATURES];
  bit          feat_seen [MAX_SAMPLES][MAX_FEATURES];
  bit          label_seen [MAX_SAMPLES];
  longint      logistic_lut [SIG_DEPTH];
  longint      step_q, wreg_q, nsamp_q, nfeat_q;
  outcome_t    pending_q[$];
  int unsigned fails = 0;
  int unsigned cycles = 0;
  bit          squeeze_req = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // e^-a in q0.32 by taylor series and repeated e^-1
  function automatic longint unsigned neg_exp_q32(longint a);
    longint unsigned t, fr, r;
    longint s;
    longint w;
    w  = a >>> 16;
    fr = longint'(a & 64'hFFFF);
    t  = 64'd1 << 32;
    s  = longint'(t);
    for (int i = 1; i <= 12; i++) begin
      t = ((t * fr) >> 16) / longint'(i);
      s = (i % 2) ? s - longint'(t) : s + longint'(t);
    end
    r = longint'(s);
    for (longint i = 0; i < w && i < 16; i++) r = (r * EXP_M1_Q32) >> 32;
    return r;
  endfunction

  function automatic longint inv_one_plus(longint unsigned e);
    longint unsigned den;
    den = (64'd1 << 32) + e;
    return longint'(((64'd1 << 48) + (den >> 1)) / den);
  endfunction

  function automatic longint logistic_of(longint m);
    longint sh, k;
    sh = m + HALF_RANGE;
    if (sh < 0) sh = 0;
    k = (sh * SIG_DEPTH) >>> 20;
    if (k >= SIG_DEPTH) k = SIG_DEPTH - 1;
    return logistic_lut[k];
  endfunction

  function automatic longint samples_used();
    return (nsamp_q > MAX_SAMPLES) ? MAX_SAMPLES : nsamp_q;
  endfunction

  function automatic longint features_used();
    return (nfeat_q > MAX_FEATURES) ? MAX_FEATURES : nfeat_q;
  endfunction

  // one finito step on sample r, returns the dot product
  function automatic longint finito_step(int r);
    longint nf, n, acc, dot, y, g, gy, a, x, grad, delta;
    nf  = features_used();
    n   = samples_used();
    acc = 0;
    for (int c = 0; c < nf; c++)
      acc += (longint'(avg_vec[c]) * longint'(feat_mem[r][c])) >>> 16;
    dot = clamp32(acc);
    y   = label_mem[r];
    g   = logistic_of(clamp32((y * dot) >>> 16));
    gy  = (g * y) >>> 16;
    for (int c = 0; c < nf; c++) begin
      a     = avg_vec[c];
      x     = feat_mem[r][c];
      grad  = clamp32(-((gy * x) >>> 16) + ((wreg_q * a) >>> 16));
      delta = clamp32(a - z_mem[r][c] - ((step_q * grad) >>> 16));
      z_mem[r][c] = int'(clamp32(z_mem[r][c] + delta));
      avg_vec[c]  = int'(clamp32(a + delta / n));
    end
    return dot;
  endfunction

  function automatic outcome_t predict_beat(beat_t b);
    outcome_t o;
    bit row_ok, col_ok;
    row_ok = b.row < samples_used();
    col_ok = b.col < features_used();
    o.res  = '0;
    o.stat = 1'b0;
    case (b.mode)
      MODE_LOAD_FEAT: begin
        if (row_ok && col_ok) begin
          feat_mem[b.row][b.col]  = b.data;
          feat_seen[b.row][b.col] = 1'b1;
        end else o.stat = 1'b1;
      end
      MODE_LOAD_LABEL: begin
        if (row_ok) begin
          label_mem[b.row]  = b.data;
          label_seen[b.row] = 1'b1;
        end else o.stat = 1'b1;
      end
      MODE_UPDATE: begin
        if (row_ok) o.res = 32'(finito_step(b.row));
        else o.stat = 1'b1;
      end
      default: begin
        if (col_ok) o.res = avg_vec[b.col];
        else o.stat = 1'b1;
      end
    endcase
    return o;
  endfunction

  function automatic bit row_ready(int r);
    if (!label_seen[r]) return 1'b0;
    for (int c = 0; c < features_used(); c++) if (!feat_seen[r][c]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_STEP_SIZE:    step_q  = val[30:0];
      REG_REG_WEIGHT:   wreg_q  = val[30:0];
      REG_SAMPLE_COUNT: nsamp_q = val[10:0];
      default:          nfeat_q = val[6:0];
    endcase
  endtask

  task automatic set_regs(int unsigned st, int unsigned wr, int unsigned ns, int unsigned nf);
    apb_write(REG_STEP_SIZE, st);
    apb_write(REG_REG_WEIGHT, wr);
    apb_write(REG_SAMPLE_COUNT, ns);
    apb_write(REG_FEATURE_COUNT, nf);
  endtask

  // offer one beat and hold it until taken, then book its expectation
  task automatic send_beat(beat_t b);
    outcome_t o;
    in_valid_i     <= 1'b1;
    mode_i         <= b.mode;
    sample_index_i <= b.row;
    coord_index_i  <= b.col;
    data_value_i   <= b.data;
    do @(posedge clk_i); while (!in_ready_o);
    o = predict_beat(b);
    if (b.typed) begin
      o.res  = b.res;
      o.stat = b.stat;
    end
    pending_q = {pending_q, o};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] feature_value();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 262143) - 131072;
  endfunction

  function automatic logic [31:0] label_value();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
  endfunction

  // mostly well formed: fill a row, then update and read; some noise
  function automatic beat_t random_beat();
    beat_t b;
    int n, nf, r, pick;
    n  = samples_used();
    nf = features_used();
    b.typed = 1'b0;
    b.res   = '0;
    b.stat  = 1'b0;
    b.col   = $urandom_range(0, 63);
    pick    = $urandom_range(0, 99);
    if (n == 0 || pick < 10) begin
      b.mode = mode_e'($urandom_range(0, 3));
      b.row  = $urandom_range(0, 1023);
      b.data = $urandom;
      if (b.mode == MODE_UPDATE && b.row < n && !row_ready(b.row)) b.mode = MODE_READ_AVG;
      return b;
    end
    r     = $urandom_range(0, (n < 8 ? n : 8) - 1);
    b.row = r;
    if (!row_ready(r)) begin
      if (!label_seen[r]) begin
        b.mode = MODE_LOAD_LABEL;
        b.data = label_value();
      end else begin
        b.mode = MODE_LOAD_FEAT;
        b.data = feature_value();
        for (int c = nf - 1; c >= 0; c--) if (!feat_seen[r][c]) b.col = c;
      end
    end else if (pick < 45) begin
      b.mode = MODE_UPDATE;
      b.data = $urandom;
    end else if (pick < 65 && nf > 0) begin
      b.mode = MODE_READ_AVG;
      b.col  = $urandom_range(0, nf - 1);
      b.data = $urandom;
    end else if (pick < 85 && nf > 0) begin
      b.mode = MODE_LOAD_FEAT;
      b.col  = $urandom_range(0, nf - 1);
      b.data = feature_value();
    end else begin
      b.mode = MODE_LOAD_LABEL;
      b.data = label_value();
    end
    return b;
  endfunction

  // directed rows, run with sample_count 4 and feature_count 2
  function automatic beat_t row_of(mode_e m, int r, int c, logic [31:0] d, bit t = 1'b0,
                                   logic [31:0] res = '0, logic st = 1'b0);
    beat_t b;
    b = '{m, r, c, d, t, res, st};
    return b;
  endfunction

  beat_t directed_tbl[$];

  initial begin
    phase_t phases[8];
    beat_t  b;
    int unsigned burst, gap;

    for (int k = 0; k < SIG_DEPTH; k++) begin
      longint u;
      u = ((2 * longint'(k) + 1) * HALF_RANGE) / SIG_DEPTH - HALF_RANGE;
      logistic_lut[k] = (u <= 0) ? inv_one_plus(neg_exp_q32(-u))
                                 : 65536 - inv_one_plus(neg_exp_q32(u));
    end
    step_q = 655; wreg_q = 0; nsamp_q = 1024; nfeat_q = 64;

    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_valid_i     <= 1'b0;
    mode_i         <= '0;
    sample_index_i <= '0;
    coord_index_i  <= '0;
    data_value_i   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: reset reads, range errors, extreme loads, updates
    set_regs(32'h8000, 32'h1000, 4, 2);
    directed_tbl = '{
      row_of(MODE_READ_AVG, 0, 0, 0, 1, 0, 0),
      row_of(MODE_READ_AVG, 0, 1, 32'hFFFF_FFFF, 1, 0, 0),
      row_of(MODE_READ_AVG, 1023, 63, 0, 1, 0, 1),
      row_of(MODE_LOAD_FEAT, 5, 0, 32'h1234, 1, 0, 1),
      row_of(MODE_LOAD_FEAT, 0, 5, 32'h1234, 1, 0, 1),
      row_of(MODE_LOAD_LABEL, 1023, 0, 32'h0001_0000, 1, 0, 1),
      row_of(MODE_UPDATE, 4, 0, 0, 1, 0, 1),
      row_of(MODE_LOAD_FEAT, 0, 0, 32'h7FFF_FFFF, 1, 0, 0),
      row_of(MODE_LOAD_FEAT, 0, 1, 32'h8000_0000, 1, 0, 0),
      row_of(MODE_LOAD_LABEL, 0, 63, 32'h0001_0000, 1, 0, 0),
      row_of(MODE_UPDATE, 0, 0, 0),
      row_of(MODE_READ_AVG, 0, 0, 0),
      row_of(MODE_READ_AVG, 3, 1, 0),
      row_of(MODE_LOAD_FEAT, 3, 0, 32'h0001_0000),
      row_of(MODE_LOAD_FEAT, 3, 1, 32'hFFFF_8000),
      row_of(MODE_LOAD_LABEL, 3, 0, 32'hFFFF_0000),
      row_of(MODE_UPDATE, 3, 0, 0),
      row_of(MODE_UPDATE, 3, 0, 0),
      row_of(MODE_UPDATE, 0, 0, 0),
      row_of(MODE_READ_AVG, 0, 0, 0),
      row_of(MODE_READ_AVG, 0, 1, 0)
    };
    foreach (directed_tbl[i]) send_beat(directed_tbl[i]);
    drain();

    // random phases over several register settings, extremes included
    phases = '{
      '{6554, 0, 16, 4, 200, 1'b0},
      '{32768, 655, 1024, 8, 150, 1'b1},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 3, 2, 100, 1'b0},
      '{0, 0, 1, 1, 80, 1'b0},
      '{655, 65536, 2047, 64, 110, 1'b0},
      '{20000, 3000, 0, 127, 40, 1'b0},
      '{1310, 100, 64, 0, 40, 1'b0},
      '{6554, 1000, 8, 5, 170, 1'b0}
    };
    burst = 0;
    foreach (phases[p]) begin
      set_regs(phases[p].step, phases[p].wreg, phases[p].nsamp, phases[p].nfeat);
      squeeze_req = phases[p].squeeze;
      for (int i = 0; i < phases[p].count; i++) begin
        b = random_beat();
        send_beat(b);
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end else burst--;
      end
      drain();
    end

    if (fails == 0) $display("[finito_logistic_update_unit] OK");
    else $display("[finito_logistic_update_unit] ERROR");
    $finish;
  end

  // receiver: stall pattern of its own, plus one long hold-off
  initial begin
    int unsigned style, left, hold;
    bit squeezed;
    style = 0; left = 0; hold = 0; squeezed = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          $error("result beat with nothing expected: result_value %h status %b",
                 result_value_o, status_o);
          fails++;
        end else begin
          outcome_t o;
          o = pending_q.pop_front();
          if (result_value_o !== o.res) begin
            $error("result_value expected %h actual %h", o.res, result_value_o);
            fails++;
          end
          if (status_o !== o.stat) begin
            $error("status expected %b actual %b", o.stat, status_o);
            fails++;
          end
        end
      end
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        hold = 600;
      end
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = $urandom_range(20, 200);
      end else left--;
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else case (style)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ((left / 8) % 2 == 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= STALL_LIMIT) begin
      $display("[finito_logistic_update_unit] ERROR");
      $finish;
    end
  end

endmodule
